// File: hw/rtl/vpp_pkg.sv
// Shared types, constants and the divider step for the vertex projection block.
// No dependencies.
package vpp_pkg;

    localparam int COEF_W    = 32;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 6;
    localparam int IDX_W     = 3;
    localparam int FRAC_BITS = 16;
    localparam int SUM_W     = 66;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 32;
    localparam int DIV_STAGES = NUM_W;

    typedef enum logic [IDX_W-1:0] {
        REG_XCOL_A = 3'd0,
        REG_XCOL_B = 3'd1,
        REG_YCOL_A = 3'd2,
        REG_YCOL_B = 3'd3,
        REG_WCOL_A = 3'd4,
        REG_WCOL_B = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_vpp_in;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               w_was_zero;
        logic               clipped;
    } t_vpp_out;

    // fields that ride alongside the divider
    typedef struct packed {
        logic               x_neg;
        logic               y_neg;
        logic               wz;
        logic               clip;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] rem;
    } t_dstep;

    // one restoring-division bit: quotient bits shift into num from the right
    function automatic t_dstep div_step(input logic [NUM_W-1:0] num,
                                        input logic [DEN_W-1:0] rem,
                                        input logic [DEN_W-1:0] den);
        logic [DEN_W:0] sh;
        logic [DEN_W:0] diff;
        t_dstep         res;
        sh   = {rem, num[NUM_W-1]};
        diff = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            res.rem = diff[DEN_W-1:0];
            res.num = {num[NUM_W-2:0], 1'b1};
        end else begin
            res.rem = sh[DEN_W-1:0];
            res.num = {num[NUM_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/vpp_div.sv
// Pipelined unsigned divider, two lanes sharing one divisor, one bit per stage.
// Depends on vpp_pkg.
module vpp_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  vpp_pkg::t_side           i_side,
    input  logic [vpp_pkg::NUM_W-1:0] i_num_x,
    input  logic [vpp_pkg::NUM_W-1:0] i_num_y,
    input  logic [vpp_pkg::DEN_W-1:0] i_den,
    output logic                     o_valid,
    output vpp_pkg::t_side           o_side,
    output logic [vpp_pkg::NUM_W-1:0] o_quo_x,
    output logic [vpp_pkg::NUM_W-1:0] o_quo_y
);
    import vpp_pkg::*;

    logic             r_valid [DIV_STAGES];
    t_side            r_side  [DIV_STAGES];
    logic [NUM_W-1:0] r_num_x [DIV_STAGES];
    logic [NUM_W-1:0] r_num_y [DIV_STAGES];
    logic [DEN_W-1:0] r_rem_x [DIV_STAGES];
    logic [DEN_W-1:0] r_rem_y [DIV_STAGES];
    logic [DEN_W-1:0] r_den   [DIV_STAGES];

    t_dstep n_x [DIV_STAGES];
    t_dstep n_y [DIV_STAGES];

    always_comb begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                n_x[s] = div_step(i_num_x, '0, i_den);
                n_y[s] = div_step(i_num_y, '0, i_den);
            end else begin
                n_x[s] = div_step(r_num_x[s-1], r_rem_x[s-1], r_den[s-1]);
                n_y[s] = div_step(r_num_y[s-1], r_rem_y[s-1], r_den[s-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_side[s] <= r_side[s-1];
                r_den[s]  <= r_den[s-1];
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_num_x[s] <= n_x[s].num;
                r_rem_x[s] <= n_x[s].rem;
                r_num_y[s] <= n_y[s].num;
                r_rem_y[s] <= n_y[s].rem;
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    assign o_quo_x = r_num_x[DIV_STAGES-1];
    assign o_quo_y = r_num_y[DIV_STAGES-1];

endmodule

// File: hw/rtl/vertex_project_perspective_top.sv
// Vertex projection: matrix columns x, y, w, then perspective divide.
// Depends on vpp_pkg and vpp_div.
//
// Usage: write the six coefficient registers through i_cfg_we/i_cfg_idx/
// i_cfg_data while the pipeline is empty. Each register holds two signed
// Q16.16 coefficients, lower matrix row in bits 31..0.
// Input beats (i_in_valid, o_in_stall, i_in_data) carry one point; each
// produces exactly one output beat (o_out_valid, i_out_stall, o_out_data).
// The registered stages, in order: multiplier products, column sums,
// saturation, the bit-per-stage divider, and one output register.
// One beat per cycle while o_in_stall is low; the divider is most of the depth.
// The whole pipeline advances together whenever the output register is empty
// or being taken; when the receiver stalls with a full output register,
// o_in_stall rises and every stage holds its beat.
// Reset clears all valid bits and all coefficients to zero.
module vertex_project_perspective_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vpp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [vpp_pkg::REG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  vpp_pkg::t_vpp_in            i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output vpp_pkg::t_vpp_out           o_out_data
);
    import vpp_pkg::*;

    logic [REG_W-1:0] r_coef [NUM_REGS];
    logic             adv;

    // stage 1: products
    logic               r1_valid;
    logic signed [63:0] r1_p  [3][3];
    logic signed [31:0] r1_m3 [3];
    // stage 2: exact sums
    logic               r2_valid;
    logic signed [SUM_W-1:0] r2_sum [3];
    // stage 3: floored, saturated columns
    logic               r3_valid;
    t_side              r3_side;
    logic [NUM_W-1:0]   r3_num_x;
    logic [NUM_W-1:0]   r3_num_y;
    logic [DEN_W-1:0]   r3_den;

    logic               d_valid;
    t_side              d_side;
    logic [NUM_W-1:0]   d_qx;
    logic [NUM_W-1:0]   d_qy;

    logic               r_out_valid;
    t_vpp_out           r_out;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_XCOL_A: r_coef[0] <= i_cfg_data;
                REG_XCOL_B: r_coef[1] <= i_cfg_data;
                REG_YCOL_A: r_coef[2] <= i_cfg_data;
                REG_YCOL_B: r_coef[3] <= i_cfg_data;
                REG_WCOL_A: r_coef[4] <= i_cfg_data;
                REG_WCOL_B: r_coef[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // column products
    logic signed [63:0] n1_p [3][3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n1_p[c][0] = i_in_data.pos_x * $signed(r_coef[2*c][31:0]);
            n1_p[c][1] = i_in_data.pos_y * $signed(r_coef[2*c][63:32]);
            n1_p[c][2] = i_in_data.pos_z * $signed(r_coef[2*c+1][31:0]);
        end
    end

    logic signed [SUM_W-1:0] n2_sum [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n2_sum[c] = SUM_W'(r1_p[c][0]) + SUM_W'(r1_p[c][1]) + SUM_W'(r1_p[c][2])
                      + (SUM_W'(r1_m3[c]) <<< FRAC_BITS);
        end
    end

    // floor to Q16.16 and clamp
    logic signed [SUM_W-1:0] fl  [3];
    logic signed [31:0]      col [3];
    logic [2:0]              col_clip;
    logic [DEN_W-1:0]        mag_x;
    logic [DEN_W-1:0]        mag_y;
    t_side                   n3_side;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fl[c] = r2_sum[c] >>> FRAC_BITS;
            if (fl[c] > SUM_W'(64'sd2147483647)) begin
                col[c]      = 32'sh7fffffff;
                col_clip[c] = 1'b1;
            end else if (fl[c] < -SUM_W'(64'sd2147483648)) begin
                col[c]      = 32'sh80000000;
                col_clip[c] = 1'b1;
            end else begin
                col[c]      = fl[c][31:0];
                col_clip[c] = 1'b0;
            end
        end
        mag_x = col[0][31] ? (~col[0] + 32'd1) : col[0];
        mag_y = col[1][31] ? (~col[1] + 32'd1) : col[1];
        n3_side.x_neg = col[0][31] ^ col[2][31];
        n3_side.y_neg = col[1][31] ^ col[2][31];
        n3_side.wz    = (col[2] == 32'sd0);
        n3_side.clip  = |col_clip;
        n3_side.cx    = col[0];
        n3_side.cy    = col[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= i_in_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_p[c][k] <= n1_p[c][k];
                end
                r1_m3[c]  <= $signed(r_coef[2*c+1][63:32]);
                r2_sum[c] <= n2_sum[c];
            end
            r3_side  <= n3_side;
            r3_num_x <= {mag_x, {FRAC_BITS{1'b0}}};
            r3_num_y <= {mag_y, {FRAC_BITS{1'b0}}};
            r3_den   <= col[2][31] ? (~col[2] + 32'd1) : col[2];
        end
    end

    vpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r3_valid),
        .i_side  (r3_side),
        .i_num_x (r3_num_x),
        .i_num_y (r3_num_y),
        .i_den   (r3_den),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_quo_x (d_qx),
        .o_quo_y (d_qy)
    );

    // sign and clamp the quotients
    logic [NUM_W-1:0]   q_mag [2];
    logic               q_neg [2];
    logic signed [31:0] q_val [2];
    logic [1:0]         q_clip;
    t_vpp_out           n_out;
    always_comb begin
        q_mag[0] = d_qx;
        q_mag[1] = d_qy;
        q_neg[0] = d_side.x_neg;
        q_neg[1] = d_side.y_neg;
        for (int k = 0; k < 2; k++) begin
            if (q_neg[k]) begin
                if (q_mag[k] > NUM_W'(48'h80000000)) begin
                    q_val[k]  = 32'sh80000000;
                    q_clip[k] = 1'b1;
                end else begin
                    q_val[k]  = ~q_mag[k][31:0] + 32'd1;
                    q_clip[k] = 1'b0;
                end
            end else begin
                if (q_mag[k] > NUM_W'(48'h7fffffff)) begin
                    q_val[k]  = 32'sh7fffffff;
                    q_clip[k] = 1'b1;
                end else begin
                    q_val[k]  = q_mag[k][31:0];
                    q_clip[k] = 1'b0;
                end
            end
        end
        n_out.w_was_zero = d_side.wz;
        if (d_side.wz) begin
            n_out.screen_x = d_side.cx;
            n_out.screen_y = d_side.cy;
            n_out.clipped  = d_side.clip;
        end else begin
            n_out.screen_x = q_val[0];
            n_out.screen_y = q_val[1];
            n_out.clipped  = d_side.clip | (|q_clip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
